>>> sv/gsrp_pkg.sv
package gsrp_pkg;

    // Frame layout
    localparam logic [7:0] HDR_START = 8'hFF;
    localparam logic [7:0] CMD_RESET = 8'h86;
    localparam int unsigned POS_W = 4;
    localparam logic [POS_W-1:0] POS_HDR = 4'd0;
    localparam logic [POS_W-1:0] POS_CMD = 4'd1;
    localparam logic [POS_W-1:0] POS_VAL_HI = 4'd2;
    localparam logic [POS_W-1:0] POS_VAL_LO = 4'd3;
    localparam logic [POS_W-1:0] POS_CHECK = 4'd8;

    typedef logic [POS_W-1:0] t_pos;

    // One reply result
    typedef struct packed {
        logic [15:0] frame_value;
        logic        checksum_ok;
        logic [15:0] stored_value;
    } t_result;

endpackage

>>> sv/gsrp_parse.sv
module gsrp_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_accept,
    input  logic [7:0]       i_rx_byte,
    output logic             o_at_check,
    output logic             o_res_valid,
    output gsrp_pkg::t_result o_res
);
    import gsrp_pkg::*;

    logic [7:0]  r_cmd;
    t_pos        r_pos, n_pos;
    logic [7:0]  r_sum, n_sum;
    logic [15:0] r_cap, n_cap;
    logic [15:0] r_good, n_good;
    logic [7:0]  expect_sum;
    logic        sum_ok;

    // Expected checksum byte is the two's complement of the running sum
    assign expect_sum = 8'd0 - r_sum;
    assign sum_ok     = (expect_sum == i_rx_byte);
    assign o_at_check = (r_pos >= POS_CHECK);

    // Advance the frame position and build the result
    always_comb begin
        n_pos       = r_pos;
        n_sum       = r_sum;
        n_cap       = r_cap;
        n_good      = r_good;
        o_res_valid = 1'b0;
        o_res.frame_value  = r_cap;
        o_res.checksum_ok  = sum_ok;
        o_res.stored_value = sum_ok ? r_cap : r_good;
        if (i_accept) begin
            if (r_pos == POS_HDR) begin
                n_pos = (i_rx_byte == HDR_START) ? POS_CMD : POS_HDR;
                n_sum = 8'd0;
            end else if (r_pos == POS_CMD && i_rx_byte != r_cmd) begin
                n_pos = POS_HDR;
                n_sum = 8'd0;
            end else if (r_pos >= POS_CHECK) begin
                o_res_valid = 1'b1;
                if (sum_ok) begin
                    n_good = r_cap;
                end
                n_pos = POS_HDR;
                n_sum = 8'd0;
            end else begin
                if (r_pos == POS_VAL_HI) begin
                    n_cap = {i_rx_byte, 8'h00};
                end else if (r_pos == POS_VAL_LO) begin
                    n_cap = {r_cap[15:8], i_rx_byte};
                end
                n_sum = r_sum + i_rx_byte;
                n_pos = r_pos + t_pos'(1);
            end
        end
    end

    // Hold frame state and the command register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd  <= CMD_RESET;
            r_pos  <= POS_HDR;
            r_sum  <= 8'd0;
            r_cap  <= 16'd0;
            r_good <= 16'd0;
        end else begin
            if (i_cfg_valid) begin
                r_cmd <= i_cfg_data;
            end
            r_pos  <= n_pos;
            r_sum  <= n_sum;
            r_cap  <= n_cap;
            r_good <= n_good;
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_CHECK) else $error("frame position beyond checksum byte");
    a_res_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_pos == POS_HDR && r_sum == 8'd0))
        else $error("parser did not restart after result");
    a_good_on_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.checksum_ok) |=> (r_good == $past(r_cap)))
        else $error("good value not updated on passing frame");
    a_good_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_res_valid && o_res.checksum_ok) |=> $stable(r_good))
        else $error("good value changed without passing frame");

endmodule

>>> sv/gsrp_out.sv
module gsrp_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  gsrp_pkg::t_result i_res,
    input  logic              i_res_stall,
    output logic              o_full_stalled,
    output logic              o_res_valid,
    output gsrp_pkg::t_result o_res
);
    import gsrp_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_full_stalled = r_valid & i_res_stall;
    assign o_res_valid    = r_valid;
    assign o_res          = r_res;

    // Hold result until transfer, load a new one when taken or empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full_stalled |-> !i_load) else $error("result register overrun");

endmodule

>>> sv/gas_sensor_reply_parser.sv
// Gas sensor reply parser: takes the received bytes of a 9-byte reply frame
// (0xFF, command code, value high, value low, four bytes, checksum) one per
// transfer and gives one result on each checksum byte, holding the captured
// concentration, a pass flag and the last concentration that passed. A byte
// that breaks the header is dropped and the parser waits for a new 0xFF.
// Bytes pass through the frame-state registers and are accepted back to back;
// the result register sits between parser and output, so input is stalled only
// when a checksum byte would arrive while a previous result is still waiting.
// The command code register resets to 0x86 and is written through the
// configuration channel, which is always ready.
module gas_sensor_reply_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [15:0] o_frame_value,
    output logic        o_checksum_ok,
    output logic [15:0] o_stored_value
);
    import gsrp_pkg::*;

    logic    accept;
    logic    at_check;
    logic    full_stalled;
    logic    res_load;
    t_result res_next;
    t_result res_out;

    assign o_cfg_ready = 1'b1;
    assign o_rx_stall  = full_stalled & at_check;
    assign accept      = i_rx_valid & ~o_rx_stall;

    gsrp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .o_at_check  (at_check),
        .o_res_valid (res_load),
        .o_res       (res_next)
    );

    gsrp_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (res_load),
        .i_res          (res_next),
        .i_res_stall    (i_res_stall),
        .o_full_stalled (full_stalled),
        .o_res_valid    (o_res_valid),
        .o_res          (res_out)
    );

    assign o_frame_value  = res_out.frame_value;
    assign o_checksum_ok  = res_out.checksum_ok;
    assign o_stored_value = res_out.stored_value;

endmodule
